### design/wsd_pkg.sv
// Package for the WebSocket client frame deframer.
// Holds the parse phases, result kinds, queue item types and reset constants.
// Has no dependencies; every design file but wsd_fifo imports it.
package wsd_pkg;

  localparam int DATA_W = 8;
  localparam int LEN_W = 16;
  localparam int APB_DW = 32;
  localparam int APB_AW = 3;

  localparam int IQ_DEPTH_DEF = 2;
  localparam int OQ_DEPTH_DEF = 2;

  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 16'd991;

  localparam logic [3:0] OP_TEXT = 4'h1;
  localparam logic [3:0] OP_CLOSE = 4'h8;

  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  localparam logic REG_MAX_LEN = 1'b0;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_HDR2    = 4'd1,
    PH_EXT_HI  = 4'd2,
    PH_EXT_LO  = 4'd3,
    PH_KEY0    = 4'd4,
    PH_KEY1    = 4'd5,
    PH_KEY2    = 4'd6,
    PH_KEY3    = 4'd7,
    PH_PAYLOAD = 4'd8
  } phase_t;

  typedef enum logic [2:0] {
    KIND_TEXT        = 3'd0,
    KIND_EMPTY       = 3'd1,
    KIND_CLOSE       = 3'd2,
    KIND_IGNORED     = 3'd3,
    KIND_UNSUPPORTED = 3'd4,
    KIND_TOO_LONG    = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    LEN_SHORT = 2'd0,
    LEN_EXT16 = 2'd1,
    LEN_EXT64 = 2'd2
  } len_code_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] data;
    len_code_t         len_code;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    kind_t             kind;
    logic              last;
  } out_item_t;

endpackage

### design/wsd_fifo.sv
// Small register-based queue used between the parts of the deframer.
// Depends on nothing but its parameters.
module wsd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic do_push, do_pop;

  assign full = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10: begin
          count <= count + CW'(1);
        end
        2'b01: begin
          count <= count - CW'(1);
        end
        default: begin
          count <= count;
        end
      endcase
    end
  end

endmodule

### design/wsd_front.sv
// Front part of the deframer: takes received bytes and classifies the length code.
// Depends on wsd_pkg and feeds the input queue.
module wsd_front import wsd_pkg::*; (
  input  logic              push,
  input  logic [DATA_W-1:0] rx_byte,
  input  logic              frame_start,
  input  logic              q_full,
  output logic              full,
  output logic              q_push,
  output in_item_t          q_item
);

  assign full = q_full;
  assign q_push = push && !q_full;

  always_comb begin
    q_item.start = frame_start;
    q_item.data = rx_byte;
    if (rx_byte[6:0] == LEN7_EXT64) begin
      q_item.len_code = LEN_EXT64;
    end else if (rx_byte[6:0] == LEN7_EXT16) begin
      q_item.len_code = LEN_EXT16;
    end else begin
      q_item.len_code = LEN_SHORT;
    end
  end

endmodule

### design/wsd_back.sv
// Back part of the deframer: the header parser, key capture and payload unmasking.
// Depends on wsd_pkg; reads the input queue and writes the result queue.
module wsd_back import wsd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [LEN_W-1:0] max_len,
  input  logic             in_valid,
  input  in_item_t         in_item,
  output logic             in_pop,
  input  logic             out_full,
  output logic             out_push,
  output out_item_t        out_item
);

  phase_t phase, phase_next;
  logic [3:0] opcode;
  logic mask;
  logic [LEN_W-1:0] plen;
  logic [LEN_W-1:0] pidx;
  logic [DATA_W-1:0] key [4];

  logic take;
  logic [LEN_W-1:0] len_sel;
  logic mask_sel;
  logic lk_close, lk_text, lk_too_long;
  logic [LEN_W-1:0] pidx_inc;
  logic pay_last;
  logic emit;
  kind_t kind;
  logic [DATA_W-1:0] res_data;
  logic res_last;

  assign take = in_valid && !out_full;
  assign in_pop = take;

  assign len_sel = (phase == PH_HDR2) ? {9'd0, in_item.data[6:0]}
                                      : {plen[LEN_W-1:DATA_W], in_item.data};
  assign mask_sel = (phase == PH_HDR2) ? in_item.data[7] : mask;
  assign lk_close = (opcode == OP_CLOSE) && mask_sel;
  assign lk_text = (opcode == OP_TEXT) && mask_sel;
  assign lk_too_long = len_sel > max_len;

  assign pidx_inc = pidx + LEN_W'(1);
  assign pay_last = (pidx_inc == plen);

  always_comb begin
    phase_next = phase;
    if (take) begin
      if (in_item.start) begin
        phase_next = PH_HDR2;
      end else begin
        case (phase)
          PH_HDR2, PH_EXT_LO: begin
            if (phase == PH_HDR2 && in_item.len_code == LEN_EXT64) begin
              phase_next = PH_IDLE;
            end else if (phase == PH_HDR2 && in_item.len_code == LEN_EXT16) begin
              phase_next = PH_EXT_HI;
            end else if (lk_text && !lk_close && !lk_too_long) begin
              phase_next = PH_KEY0;
            end else begin
              phase_next = PH_IDLE;
            end
          end
          PH_EXT_HI: begin
            phase_next = PH_EXT_LO;
          end
          PH_KEY0: begin
            phase_next = PH_KEY1;
          end
          PH_KEY1: begin
            phase_next = PH_KEY2;
          end
          PH_KEY2: begin
            phase_next = PH_KEY3;
          end
          PH_KEY3: begin
            phase_next = (plen == '0) ? PH_IDLE : PH_PAYLOAD;
          end
          PH_PAYLOAD: begin
            phase_next = pay_last ? PH_IDLE : PH_PAYLOAD;
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_comb begin
    emit = 1'b0;
    kind = KIND_IGNORED;
    res_data = '0;
    res_last = 1'b1;
    if (take && !in_item.start) begin
      case (phase)
        PH_HDR2, PH_EXT_LO: begin
          if (phase == PH_HDR2 && in_item.len_code == LEN_EXT64) begin
            emit = 1'b1;
            kind = KIND_UNSUPPORTED;
          end else if (phase == PH_HDR2 && in_item.len_code == LEN_EXT16) begin
            emit = 1'b0;
          end else if (lk_close) begin
            emit = 1'b1;
            kind = KIND_CLOSE;
          end else if (lk_text) begin
            emit = lk_too_long;
            kind = KIND_TOO_LONG;
          end else begin
            emit = 1'b1;
            kind = KIND_IGNORED;
          end
        end
        PH_KEY3: begin
          emit = (plen == '0);
          kind = KIND_EMPTY;
        end
        PH_PAYLOAD: begin
          emit = 1'b1;
          kind = KIND_TEXT;
          res_data = in_item.data ^ key[pidx[1:0]];
          res_last = pay_last;
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
  end

  assign out_push = emit;
  assign out_item.data = res_data;
  assign out_item.kind = kind;
  assign out_item.last = res_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      opcode <= '0;
      mask <= 1'b0;
      plen <= '0;
      pidx <= '0;
    end else begin
      phase <= phase_next;
      if (take) begin
        if (in_item.start) begin
          opcode <= in_item.data[3:0];
          mask <= 1'b0;
          plen <= '0;
          pidx <= '0;
        end else begin
          case (phase)
            PH_HDR2: begin
              mask <= in_item.data[7];
              if (in_item.len_code == LEN_SHORT) begin
                plen <= len_sel;
              end
            end
            PH_EXT_HI: begin
              plen <= {in_item.data, 8'd0};
            end
            PH_EXT_LO: begin
              plen <= len_sel;
            end
            PH_KEY3: begin
              pidx <= '0;
            end
            PH_PAYLOAD: begin
              pidx <= pidx_inc;
            end
            default: begin
              pidx <= pidx;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && !in_item.start) begin
      case (phase)
        PH_KEY0: begin
          key[0] <= in_item.data;
        end
        PH_KEY1: begin
          key[1] <= in_item.data;
        end
        PH_KEY2: begin
          key[2] <= in_item.data;
        end
        PH_KEY3: begin
          key[3] <= in_item.data;
        end
        default: begin
          key[0] <= key[0];
        end
      endcase
    end
  end

endmodule

### design/websocket_client_frame_deframer.sv
// WebSocket client frame deframer, top level: front, input queue, parser, result queue.
// A byte's result passes through the input queue, the parser and the result queue.
// Throughput is one byte per cycle while bytes wait and the result queue is not full.
// The front stalls only when the input queue is full; the parser stalls when results back up.
// Synchronous active-high reset empties both queues, idles the parser and loads the limit 991.
// Depends on wsd_pkg, wsd_front, wsd_fifo and wsd_back.
module websocket_client_frame_deframer import wsd_pkg::*; #(
  parameter int IQ_DEPTH = IQ_DEPTH_DEF,
  parameter int OQ_DEPTH = OQ_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [DATA_W-1:0] rx_byte,
  input  logic              frame_start,
  output logic              empty,
  input  logic              pop,
  output logic [DATA_W-1:0] out_byte,
  output logic [2:0]        out_kind,
  output logic              last_of_frame,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic [LEN_W-1:0] max_len;
  logic iq_full, iq_push, iq_empty, iq_pop;
  in_item_t iq_wdata, iq_rdata;
  logic oq_full, oq_push;
  out_item_t oq_wdata, oq_rdata;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_LEN) ? {{(APB_DW - LEN_W){1'b0}}, max_len} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= MAX_LEN_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_LEN) begin
      max_len <= pwdata[LEN_W-1:0];
    end
  end

  wsd_front u_front (
    .push        (push),
    .rx_byte     (rx_byte),
    .frame_start (frame_start),
    .q_full      (iq_full),
    .full        (full),
    .q_push      (iq_push),
    .q_item      (iq_wdata)
  );

  wsd_fifo #(
    .WIDTH ($bits(in_item_t)),
    .DEPTH (IQ_DEPTH)
  ) u_in_q (
    .clk   (clk),
    .rst   (rst),
    .push  (iq_push),
    .wdata (iq_wdata),
    .full  (iq_full),
    .pop   (iq_pop),
    .rdata (iq_rdata),
    .empty (iq_empty)
  );

  wsd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .max_len  (max_len),
    .in_valid (!iq_empty),
    .in_item  (iq_rdata),
    .in_pop   (iq_pop),
    .out_full (oq_full),
    .out_push (oq_push),
    .out_item (oq_wdata)
  );

  wsd_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OQ_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (oq_push),
    .wdata (oq_wdata),
    .full  (oq_full),
    .pop   (pop),
    .rdata (oq_rdata),
    .empty (empty)
  );

  assign out_byte = oq_rdata.data;
  assign out_kind = oq_rdata.kind;
  assign last_of_frame = oq_rdata.last;

endmodule

### design/wsd_checker.sv
// Port-level checker for the WebSocket client frame deframer, bound to the top level.
// Depends on wsd_pkg and watches only the top-level ports.
module wsd_checker import wsd_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              full,
  input logic              empty,
  input logic              pop,
  input logic [DATA_W-1:0] out_byte,
  input logic [2:0]        out_kind,
  input logic              last_of_frame,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [APB_AW-1:0] paddr,
  input logic [APB_DW-1:0] pwdata,
  input logic [APB_DW-1:0] prdata,
  input logic              pready
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("Queues are not empty after reset.");

  a_event_ends_frame: assert property (@(posedge clk) disable iff (rst)
    !empty && out_kind != KIND_TEXT |-> last_of_frame && out_byte == 8'd0)
    else $error("A non-text result does not close its frame with a zero byte.");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> out_kind <= KIND_TOO_LONG)
    else $error("Result kind is out of range.");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(out_byte) && $stable(out_kind)
    && $stable(last_of_frame))
    else $error("A waiting result changed before its transaction completed.");

  a_limit_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready && paddr[2] == REG_MAX_LEN
    |=> paddr[2] != REG_MAX_LEN || prdata[LEN_W-1:0] == $past(pwdata[LEN_W-1:0]))
    else $error("Payload limit does not read back the written value.");

endmodule

bind websocket_client_frame_deframer wsd_checker u_wsd_checker (.*);

### verif/websocket_client_frame_deframer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for websocket_client_frame_deframer: frame bytes in, unmasked results out.
// A scoreboard class parses accepted bytes and checks every popped transaction; depends on wsd_pkg.
module websocket_client_frame_deframer_tb;
  import wsd_pkg::*;

  class frame_scoreboard;
    out_item_t   pending_results[$];
    logic [15:0] max_len;
    phase_t      phase;
    logic [3:0]  opcode;
    logic        masked;
    logic [15:0] frame_len;
    logic [15:0] payload_idx;
    logic [7:0]  mask_bytes[4];
    int          errors;

    function new();
      max_len = MAX_LEN_RESET;
      phase = PH_IDLE;
      opcode = '0;
      masked = 1'b0;
      frame_len = '0;
      payload_idx = '0;
      errors = 0;
      foreach (mask_bytes[i]) mask_bytes[i] = '0;
    endfunction

    function void add_result(logic [7:0] d, kind_t k, logic l);
      out_item_t r;
      r.data = d;
      r.kind = k;
      r.last = l;
      pending_results.push_back(r);
    endfunction

    function void length_known();
      if (opcode == OP_CLOSE && masked) begin
        phase = PH_IDLE;
        add_result('0, KIND_CLOSE, 1'b1);
      end else if (opcode == OP_TEXT && masked) begin
        if (frame_len > max_len) begin
          phase = PH_IDLE;
          add_result('0, KIND_TOO_LONG, 1'b1);
        end else begin
          phase = PH_KEY0;
        end
      end else begin
        phase = PH_IDLE;
        add_result('0, KIND_IGNORED, 1'b1);
      end
    endfunction

    function void predict_byte(logic [7:0] b, logic st);
      logic [15:0] nxt;
      if (st) begin
        opcode = b[3:0];
        masked = 1'b0;
        frame_len = '0;
        payload_idx = '0;
        phase = PH_HDR2;
        return;
      end
      case (phase)
        PH_HDR2: begin
          masked = b[7];
          if (b[6:0] == LEN7_EXT64) begin
            phase = PH_IDLE;
            add_result('0, KIND_UNSUPPORTED, 1'b1);
          end else if (b[6:0] == LEN7_EXT16) begin
            phase = PH_EXT_HI;
          end else begin
            frame_len = {9'd0, b[6:0]};
            length_known();
          end
        end
        PH_EXT_HI: begin
          frame_len = {b, 8'd0};
          phase = PH_EXT_LO;
        end
        PH_EXT_LO: begin
          frame_len = frame_len | {8'd0, b};
          length_known();
        end
        PH_KEY0, PH_KEY1, PH_KEY2, PH_KEY3: begin
          mask_bytes[int'(phase) - int'(PH_KEY0)] = b;
          if (phase == PH_KEY3) begin
            payload_idx = '0;
            if (frame_len == 0) begin
              phase = PH_IDLE;
              add_result('0, KIND_EMPTY, 1'b1);
            end else begin
              phase = PH_PAYLOAD;
            end
          end else begin
            phase = phase_t'(phase + 4'd1);
          end
        end
        PH_PAYLOAD: begin
          nxt = payload_idx + 16'd1;
          add_result(b ^ mask_bytes[payload_idx[1:0]], KIND_TEXT, nxt == frame_len);
          if (nxt == frame_len) phase = PH_IDLE;
          payload_idx = nxt;
        end
        default: begin
          phase = PH_IDLE;
        end
      endcase
    endfunction

    function void check_result(logic [7:0] d, logic [2:0] k, logic l);
      out_item_t e;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result byte=%h kind=%0d last=%b", $time, d, k, l);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      if (d !== e.data) begin
        $display("%0t: out_byte expected %h actual %h", $time, e.data, d);
        errors++;
      end
      if (k !== e.kind) begin
        $display("%0t: out_kind expected %0d actual %0d", $time, e.kind, k);
        errors++;
      end
      if (l !== e.last) begin
        $display("%0t: last_of_frame expected %b actual %b", $time, e.last, l);
        errors++;
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              push;
  logic              full;
  logic [DATA_W-1:0] rx_byte;
  logic              frame_start;
  logic              empty;
  logic              pop;
  logic [DATA_W-1:0] out_byte;
  logic [2:0]        out_kind;
  logic              last_of_frame;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  frame_scoreboard sb = new();
  bit calm;
  bit hold_req;
  bit hold_done;
  int phase_items;

  websocket_client_frame_deframer i_dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .rx_byte      (rx_byte),
    .frame_start  (frame_start),
    .empty        (empty),
    .pop          (pop),
    .out_byte     (out_byte),
    .out_kind     (out_kind),
    .last_of_frame(last_of_frame),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3ms;
    $display("websocket_client_frame_deframer_tb: FAIL");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic st);
    if (!calm && $urandom_range(99) < 38) begin
      push <= 1'b0;
      @(posedge clk);
      while (!calm && $urandom_range(99) < 38) @(posedge clk);
    end
    push <= 1'b1;
    rx_byte <= b;
    frame_start <= st;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.predict_byte(b, st);
    phase_items++;
  endtask

  task automatic send_key_and_payload(input int n);
    repeat (4) send_byte(8'($urandom), 1'b0);
    repeat (n) send_byte(8'($urandom), 1'b0);
  endtask

  task automatic send_random_frame();
    logic [3:0]  op;
    logic        m;
    logic [15:0] len;
    int          sel;
    int          n;
    sel = $urandom_range(99);
    if (sel < 8) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom), $urandom_range(9) == 0);
      return;
    end
    op = (sel < 65) ? OP_TEXT : (sel < 78) ? OP_CLOSE : 4'($urandom);
    m = $urandom_range(99) < 85;
    send_byte({4'($urandom), op}, 1'b1);
    if ($urandom_range(99) < 3) return;
    sel = $urandom_range(99);
    if (sel < 6) begin
      send_byte({m, LEN7_EXT64}, 1'b0);
      len = '0;
    end else if (sel < 70) begin
      len = (sel < 20) ? 16'($urandom_range(0, 125)) : 16'($urandom_range(0, 12));
      send_byte({m, len[6:0]}, 1'b0);
    end else begin
      n = $urandom_range(99);
      if (n < 50) len = 16'($urandom_range(0, 30));
      else if (n < 80) len = sb.max_len + 16'($urandom_range(0, 2)) - 16'd1;
      else len = 16'($urandom);
      send_byte({m, LEN7_EXT16}, 1'b0);
      send_byte(len[15:8], 1'b0);
      send_byte(len[7:0], 1'b0);
    end
    if (sel >= 6 && op == OP_TEXT && m && len <= sb.max_len) begin
      n = (len <= 40) ? int'(len) : $urandom_range(0, 8);
      if ($urandom_range(99) < 6) n = $urandom_range(0, n);
      send_key_and_payload(n);
    end
    if ($urandom_range(99) < 15) repeat ($urandom_range(1, 2)) send_byte(8'($urandom), 1'b0);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_max_len(input logic [15:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_AW'(4 * REG_MAX_LEN);
    pwdata <= APB_DW'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.max_len = v;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin
    int hold_left;
    pop <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) sb.check_result(out_byte, out_kind, last_of_frame);
      if (hold_req) begin
        hold_left = 300;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= calm || ($urandom_range(99) >= 38);
      end
    end
  end

  initial begin
    logic [15:0] limits[5];
    limits = '{16'hFFFF, 16'h0000, 16'd6, 16'($urandom_range(16, 300)), MAX_LEN_RESET};
    rst <= 1'b1;
    push <= 1'b0;
    rx_byte <= '0;
    frame_start <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    calm = 1'b0;
    hold_req = 1'b0;
    hold_done = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Loose bytes before any frame start must produce nothing.
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    // Masked text frame of two bytes, then a stray byte after its end.
    send_byte(8'h81, 1'b1);
    send_byte(8'h82, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h33, 1'b0);
    // Empty masked text frame.
    send_byte(8'h81, 1'b1);
    send_byte(8'h80, 1'b0);
    send_key_and_payload(0);
    // Masked close, 64-bit length and an oversized 16-bit length.
    send_byte(8'h88, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h81, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h81, 1'b1);
    send_byte(8'hFE, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    // A new frame start abandons the frame in progress; unmasked close is ignored.
    send_byte(8'h81, 1'b1);
    send_byte(8'h88, 1'b1);
    send_byte(8'h00, 1'b0);
    drain();

    foreach (limits[i]) begin
      write_max_len(limits[i]);
      phase_items = 0;
      calm = (i == 2);
      while (phase_items < 80) begin
        if (i == 0 && phase_items >= 30 && !hold_done) begin
          hold_req = 1'b1;
          hold_done = 1'b1;
        end
        send_random_frame();
      end
      calm = 1'b0;
      drain();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("websocket_client_frame_deframer_tb: PASS");
    end else begin
      $display("websocket_client_frame_deframer_tb: FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
design/wsd_pkg.sv
design/wsd_fifo.sv
design/wsd_front.sv
design/wsd_back.sv
design/websocket_client_frame_deframer.sv
design/wsd_checker.sv
verif/websocket_client_frame_deframer_tb.sv
